FILE: sv/julia_escape_time_pixel_defines.svh
// Assertion macros for the Julia escape-time pixel block.
`ifndef JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH

// cond must hold in the same cycle as trig, outside reset
`define JETP_ASSERT_IMPL(name, clk, rst_n, trig, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("jetp: same-cycle check failed");

// cond must hold in the cycle after trig, outside reset
`define JETP_ASSERT_NEXT(name, clk, rst_n, trig, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("jetp: next-cycle check failed");

`endif

FILE: sv/jetp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Julia escape-time pixel block.
package jetp_pkg;

	localparam int unsigned Z_W        = 64;
	localparam int unsigned C_W        = 32;
	localparam int unsigned C_FRAC     = 28;
	localparam int unsigned LIM_W      = 16;
	localparam int unsigned SIZE_W     = 13;
	localparam int unsigned HALF_W     = SIZE_W - 1;
	localparam int unsigned GRAY_W     = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [LIM_W-1:0]  LIM_RESET    = 16'd256;
	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_C_REAL          = 3'd0,
		CFG_C_IMAG          = 3'd1,
		CFG_ITERATION_LIMIT = 3'd2,
		CFG_IMAGE_WIDTH     = 3'd3,
		CFG_IMAGE_HEIGHT    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [Z_W-1:0] re;
		logic signed [Z_W-1:0] im;
	} zpair_t;

	typedef struct packed {
		logic   push;
		zpair_t z;
	} q_wr_t;

	typedef struct packed {
		logic   empty;
		zpair_t z;
	} q_rd_t;

endpackage

FILE: sv/jetp_front.sv
`timescale 1ns / 1ps
// Front end: maps a pixel to its start point with two restoring dividers.
module jetp_front import jetp_pkg::*; #(
	parameter int unsigned FRAC_BITS = 28,
	parameter int unsigned DIM_BITS  = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [DIM_BITS-1:0] pixel_x,
	input  logic [DIM_BITS-1:0] pixel_y,
	input  logic [SIZE_W-1:0]   image_width,
	input  logic [SIZE_W-1:0]   image_height,
	output q_wr_t               q_wr,
	input  logic                q_full
);

	localparam int unsigned LANES  = 2;
	localparam int unsigned QUO_W  = FRAC_BITS + 2;
	localparam int unsigned DIFF_W = (DIM_BITS > HALF_W) ? DIM_BITS : HALF_W;
	localparam int unsigned NUM_W  = DIFF_W + 1;
	localparam int unsigned CMP_W  = (NUM_W > HALF_W + 2) ? NUM_W : HALF_W + 2;
	localparam int unsigned CNT_W  = $clog2(QUO_W + 1);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t                 state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [HALF_W-1:0]       hs_q;
	logic                    neg_q  [LANES];
	logic                    sat_q  [LANES];
	logic [HALF_W-1:0]       rem_q  [LANES];
	logic [1:0]              bits_q [LANES];
	logic [QUO_W-1:0]        quo_q  [LANES];

	logic [HALF_W-1:0]       hw, hh, hs;
	logic [DIFF_W-1:0]       p_in    [LANES];
	logic [DIFF_W-1:0]       h_in    [LANES];
	logic [DIFF_W-1:0]       diff_in [LANES];
	logic [NUM_W-1:0]        num_in  [LANES];
	logic                    neg_in  [LANES];
	logic                    sat_in  [LANES];
	logic [HALF_W:0]         rs      [LANES];
	logic [HALF_W:0]         rsub    [LANES];
	logic                    ge      [LANES];
	logic [HALF_W-1:0]       rem_nx  [LANES];
	logic [Z_W-1:0]          mag     [LANES];
	logic signed [Z_W-1:0]   val     [LANES];
	logic                    accept;

	assign accept = push && !full;
	assign full   = (state_q != F_IDLE);
	assign hw     = image_width[SIZE_W-1:1];
	assign hh     = image_height[SIZE_W-1:1];

	always_comb begin
		hs = (hw > hh) ? hw : hh;
		if (hs == '0) begin
			hs = HALF_W'(1);
		end
		p_in[0] = DIFF_W'(pixel_x);
		p_in[1] = DIFF_W'(pixel_y);
		h_in[0] = DIFF_W'(hw);
		h_in[1] = DIFF_W'(hh);
		for (int l = 0; l < LANES; l++) begin
			neg_in[l]  = p_in[l] < h_in[l];
			diff_in[l] = neg_in[l] ? (h_in[l] - p_in[l]) : (p_in[l] - h_in[l]);
			num_in[l]  = {diff_in[l], 1'b0};
			// beyond four the start point clamps to +-4.0
			sat_in[l]  = CMP_W'(num_in[l]) >= (CMP_W'(hs) << 2);
			rs[l]      = {rem_q[l], bits_q[l][1]};
			rsub[l]    = rs[l] - {1'b0, hs_q};
			ge[l]      = rs[l] >= {1'b0, hs_q};
			rem_nx[l]  = ge[l] ? rsub[l][HALF_W-1:0] : rs[l][HALF_W-1:0];
			mag[l]     = sat_q[l] ? (Z_W'(4) << FRAC_BITS) : Z_W'(quo_q[l]);
			val[l]     = neg_q[l] ? -$signed(mag[l]) : $signed(mag[l]);
		end
	end

	assign q_wr.push = (state_q == F_PUSH) && !q_full;
	assign q_wr.z.re = val[0];
	assign q_wr.z.im = val[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_DIV;
						cnt_q   <= CNT_W'(QUO_W);
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hs_q <= hs;
			for (int l = 0; l < LANES; l++) begin
				neg_q[l]  <= neg_in[l];
				sat_q[l]  <= sat_in[l];
				rem_q[l]  <= HALF_W'(num_in[l] >> 2);
				bits_q[l] <= num_in[l][1:0];
				quo_q[l]  <= '0;
			end
		end else if (state_q == F_DIV) begin
			for (int l = 0; l < LANES; l++) begin
				rem_q[l]  <= rem_nx[l];
				bits_q[l] <= {bits_q[l][0], 1'b0};
				quo_q[l]  <= {quo_q[l][QUO_W-2:0], ge[l]};
			end
		end
	end

endmodule

FILE: sv/jetp_fifo.sv
`timescale 1ns / 1ps
// Short word queue between the front end and the iteration engine.
module jetp_fifo import jetp_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  q_wr_t wr,
	output logic  full,
	input  logic  rd_en,
	output q_rd_t rd
);

	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

	zpair_t             mem_q [DEPTH];
	logic [ADDR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_wr, do_rd;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign rd.empty = (cnt_q == '0);
	assign rd.z     = mem_q[rd_ptr_q];
	assign do_wr    = wr.push && !full;
	assign do_rd    = rd_en && !rd.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + ADDR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + ADDR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr.z;
		end
	end

endmodule

FILE: sv/jetp_back.sv
`timescale 1ns / 1ps
// Iteration engine: z = z*z + c with three 32x32 multipliers, then gray scaling.
module jetp_back import jetp_pkg::*; #(
	parameter int unsigned FRAC_BITS = 28
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  q_rd_t                    q_rd,
	output logic                     q_pop,
	input  logic signed [C_W-1:0]    c_real,
	input  logic signed [C_W-1:0]    c_imag,
	input  logic [LIM_W-1:0]         iteration_limit,
	output logic                     empty,
	input  logic                     pop,
	output logic [GRAY_W-1:0]        gray_level,
	output logic [LIM_W-1:0]         escape_count
);

	localparam int unsigned SHL    = (FRAC_BITS >= C_FRAC) ? FRAC_BITS - C_FRAC : 0;
	localparam int unsigned SHR    = (FRAC_BITS < C_FRAC) ? C_FRAC - FRAC_BITS : 0;
	localparam int unsigned HW     = Z_W / 2;
	localparam int unsigned ACC_W  = 2 * Z_W;
	localparam int unsigned NUM_W  = LIM_W + GRAY_W;
	localparam logic [2:0]  MUL_LAST = 3'd4;
	localparam logic [Z_W-1:0] PROD_CAP = Z_W'(1) << 61;
	localparam logic [Z_W-1:0] FOUR     = Z_W'(4) << FRAC_BITS;

	typedef enum logic [7:0] {
		B_IDLE = 8'b0000_0001,
		B_ABS  = 8'b0000_0010,
		B_MUL  = 8'b0000_0100,
		B_FIX  = 8'b0000_1000,
		B_STEP = 8'b0001_0000,
		B_PREP = 8'b0010_0000,
		B_DIV  = 8'b0100_0000,
		B_DONE = 8'b1000_0000
	} bstate_t;

	bstate_t                state_q;
	logic [2:0]             ph_q;
	logic [LIM_W-1:0]       cnt_q, lim_q, count_q;
	logic [2:0]             dcnt_q;
	logic                   out_valid_q;

	logic signed [Z_W-1:0]  zr_q, zi_q, cr_q, ci_q, cross_q;
	logic [Z_W-1:0]         mag_r_q, mag_i_q, sq_r_q, sq_i_q;
	logic                   sign_r_q, sign_i_q;
	logic [Z_W-1:0]         pp_rr_s1, pp_ii_s1, pp_ri_s1;
	logic [1:0]             sh_s1;
	logic [ACC_W-1:0]       acc_rr_q, acc_ii_q, acc_ri_q;
	logic [LIM_W-1:0]       drem_q;
	logic [GRAY_W-1:0]      dbits_q, gq_q, gray_q;
	logic [LIM_W-1:0]       esc_q;

	logic [HW-1:0]          a_r, b_r, b_i;
	logic [Z_W-1:0]         sq_sum, cross_mag;
	logic                   escaped;
	logic [NUM_W-1:0]       gray_num;
	logic [LIM_W:0]         drs, dsub;
	logic                   dge;

	function automatic logic signed [Z_W-1:0] conv_c(input logic signed [C_W-1:0] v);
		logic [C_W:0]   m;
		logic [Z_W-1:0] m64;
		m   = v[C_W-1] ? (((C_W+1)'(1) << C_W) - {1'b0, v}) : {1'b0, v};
		m64 = (Z_W'(m) << SHL) >> SHR;
		return v[C_W-1] ? -$signed(m64) : $signed(m64);
	endfunction

	// drop the fraction, clamp the magnitude at the cap
	function automatic logic [Z_W-1:0] fix_mag(input logic [ACC_W-1:0] p);
		logic [ACC_W-1:0] r;
		r = p >> FRAC_BITS;
		return (r > ACC_W'(PROD_CAP)) ? PROD_CAP : r[Z_W-1:0];
	endfunction

	function automatic logic [ACC_W-1:0] place_pp(input logic [Z_W-1:0] pp,
		input logic [1:0] sh);
		logic [ACC_W-1:0] r;
		case (sh)
			2'd0:    r = {{Z_W{1'b0}}, pp};
			2'd1:    r = {{HW{1'b0}}, pp, {HW{1'b0}}};
			default: r = {pp, {Z_W{1'b0}}};
		endcase
		return r;
	endfunction

	assign q_pop = (state_q == B_IDLE) && !q_rd.empty;
	assign empty = !out_valid_q;
	assign gray_level   = gray_q;
	assign escape_count = esc_q;

	// phase bit 1 picks the high half of a, bit 0 the high half of b
	assign a_r = ph_q[1] ? mag_r_q[Z_W-1:HW] : mag_r_q[HW-1:0];
	assign b_r = ph_q[0] ? mag_r_q[Z_W-1:HW] : mag_r_q[HW-1:0];
	assign b_i = ph_q[0] ? mag_i_q[Z_W-1:HW] : mag_i_q[HW-1:0];

	assign sq_sum    = sq_r_q + sq_i_q;
	assign escaped   = (cnt_q != '0) && (sq_sum > FOUR);
	assign cross_mag = fix_mag(acc_ri_q);
	assign gray_num  = {count_q, {GRAY_W{1'b0}}} - NUM_W'(count_q);
	assign drs       = {drem_q, dbits_q[GRAY_W-1]};
	assign dsub      = drs - {1'b0, lim_q};
	assign dge       = drs >= {1'b0, lim_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			ph_q        <= '0;
			cnt_q       <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_rd.empty) begin
						cnt_q   <= '0;
						state_q <= (iteration_limit == '0) ? B_PREP : B_ABS;
					end
				end
				B_ABS: begin
					ph_q    <= '0;
					state_q <= B_MUL;
				end
				B_MUL: begin
					if (ph_q == MUL_LAST) begin
						state_q <= B_FIX;
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				B_FIX: state_q <= B_STEP;
				B_STEP: begin
					if (escaped || cnt_q == lim_q) begin
						state_q <= B_PREP;
					end else begin
						cnt_q   <= cnt_q + LIM_W'(1);
						state_q <= B_ABS;
					end
				end
				B_PREP: begin
					dcnt_q  <= 3'(GRAY_W - 1);
					state_q <= B_DIV;
				end
				B_DIV: begin
					dcnt_q <= dcnt_q - 3'd1;
					if (dcnt_q == '0) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				zr_q    <= q_rd.z.re;
				zi_q    <= q_rd.z.im;
				cr_q    <= conv_c(c_real);
				ci_q    <= conv_c(c_imag);
				lim_q   <= iteration_limit;
				count_q <= '0;
			end
			B_ABS: begin
				sign_r_q <= zr_q[Z_W-1];
				sign_i_q <= zi_q[Z_W-1];
				mag_r_q  <= zr_q[Z_W-1] ? Z_W'(-zr_q) : Z_W'(zr_q);
				mag_i_q  <= zi_q[Z_W-1] ? Z_W'(-zi_q) : Z_W'(zi_q);
			end
			B_MUL: begin
				pp_rr_s1 <= a_r * b_r;
				pp_ii_s1 <= (ph_q[1] ? mag_i_q[Z_W-1:HW] : mag_i_q[HW-1:0]) * b_i;
				pp_ri_s1 <= a_r * b_i;
				sh_s1    <= {1'b0, ph_q[1]} + {1'b0, ph_q[0]};
				if (ph_q == '0) begin
					acc_rr_q <= '0;
					acc_ii_q <= '0;
					acc_ri_q <= '0;
				end else begin
					acc_rr_q <= acc_rr_q + place_pp(pp_rr_s1, sh_s1);
					acc_ii_q <= acc_ii_q + place_pp(pp_ii_s1, sh_s1);
					acc_ri_q <= acc_ri_q + place_pp(pp_ri_s1, sh_s1);
				end
			end
			B_FIX: begin
				sq_r_q  <= fix_mag(acc_rr_q);
				sq_i_q  <= fix_mag(acc_ii_q);
				cross_q <= (sign_r_q ^ sign_i_q) ? -$signed(cross_mag) : $signed(cross_mag);
			end
			B_STEP: begin
				if (escaped) begin
					count_q <= cnt_q - LIM_W'(1);
				end else if (cnt_q == lim_q) begin
					count_q <= lim_q;
				end else begin
					zr_q <= $signed(sq_r_q) - $signed(sq_i_q) + cr_q;
					zi_q <= (cross_q <<< 1) + ci_q;
				end
			end
			B_PREP: begin
				// quotient fits in eight bits, so the top bits seed the remainder
				drem_q  <= gray_num[NUM_W-1:GRAY_W];
				dbits_q <= gray_num[GRAY_W-1:0];
				gq_q    <= '0;
			end
			B_DIV: begin
				drem_q  <= dge ? dsub[LIM_W-1:0] : drs[LIM_W-1:0];
				dbits_q <= {dbits_q[GRAY_W-2:0], 1'b0};
				gq_q    <= {gq_q[GRAY_W-2:0], dge};
			end
			B_DONE: begin
				if (!out_valid_q) begin
					gray_q <= (lim_q == '0) ? '0 : gq_q;
					esc_q  <= count_q;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/julia_escape_time_pixel.sv
// The front end computes the start point of an accepted pixel and writes it into the queue;
// the iteration engine then runs until the pixel escapes or the limit is reached, and a
// zero limit skips the iteration; each step forms three 64-bit products as four phases
// through three 32x32 multipliers. While the engine iterates, the front end can accept
// the next pixel and compute its start point.
// Reset (arst_n low, asynchronous) empties the queues and restores the register defaults.
`timescale 1ns / 1ps
`include "julia_escape_time_pixel_defines.svh"
// Top level of the Julia escape-time pixel block.
module julia_escape_time_pixel import jetp_pkg::*; #(
	parameter int unsigned FRAC_BITS = 28,
	parameter int unsigned DIM_BITS  = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [DIM_BITS-1:0]   pixel_x,
	input  logic [DIM_BITS-1:0]   pixel_y,
	output logic                  empty,
	input  logic                  pop,
	output logic [GRAY_W-1:0]     gray_level,
	output logic [LIM_W-1:0]      escape_count,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic signed [C_W-1:0] c_real_q, c_imag_q;
	logic [LIM_W-1:0]      limit_q;
	logic [SIZE_W-1:0]     width_q, height_q;

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q <= '0;
			c_imag_q <= '0;
			limit_q  <= LIM_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_C_REAL:          c_real_q <= cfg_data[C_W-1:0];
				CFG_C_IMAG:          c_imag_q <= cfg_data[C_W-1:0];
				CFG_ITERATION_LIMIT: limit_q  <= cfg_data[LIM_W-1:0];
				CFG_IMAGE_WIDTH:     width_q  <= cfg_data[SIZE_W-1:0];
				CFG_IMAGE_HEIGHT:    height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	jetp_front #(
		.FRAC_BITS (FRAC_BITS),
		.DIM_BITS  (DIM_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.image_width  (width_q),
		.image_height (height_q),
		.q_wr         (q_wr),
		.q_full       (q_full)
	);

	jetp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd     (q_rd)
	);

	jetp_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_rd            (q_rd),
		.q_pop           (q_pop),
		.c_real          (c_real_q),
		.c_imag          (c_imag_q),
		.iteration_limit (limit_q),
		.empty           (empty),
		.pop             (pop),
		.gray_level      (gray_level),
		.escape_count    (escape_count)
	);

	`JETP_ASSERT_IMPL(a_no_push_when_full, clk, arst_n, q_wr.push, !q_full)
	`JETP_ASSERT_IMPL(a_no_pop_when_empty, clk, arst_n, q_pop, !q_rd.empty)
	`JETP_ASSERT_NEXT(a_push_lands, clk, arst_n, q_wr.push && !q_pop, !q_rd.empty)

endmodule
